### hdl/ptpsfr_pkg.sv
// ----------------------------------------------------------------------------
// ptpsfr_pkg
// Types and constants for the Sync/Follow_Up receive machine.
// ----------------------------------------------------------------------------
package ptpsfr_pkg;

  localparam int DivW  = 62;  // delay shifted up by 30
  localparam int RatW  = 31;
  localparam int CntW  = 6;
  localparam logic [63:0] NsInSec = 64'd1000000000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SYNC  = 2'd1,
    OP_FUP   = 2'd2,
    OP_BEGIN = 2'd3
  } opcode_e;

  typedef enum logic [0:0] {
    CFG_DELAY = 1'b0,
    CFG_RATIO = 1'b1
  } cfg_reg_e;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic        pad;
    logic [7:0]  domain_number;
    logic [31:0] gm_freq_change_scaled;
    logic [15:0] gm_base_indicator;
    logic [31:0] rate_offset_scaled;
    logic [29:0] origin_nanoseconds;
    logic [47:0] origin_seconds;
    logic [63:0] correction_scaled;
    logic [7:0]  log_interval;
    logic [15:0] sequence_id;
    logic [63:0] time_ns;
    logic        port_ready;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  domain_out;
    logic [31:0] gm_freq_change_out;
    logic [15:0] gm_base_out;
    logic [29:0] origin_ns_out;
    logic [47:0] origin_sec_out;
    logic [7:0]  sync_log_interval;
    logic [15:0] correction_frac;
    logic [47:0] correction_whole_ns;
    logic [41:0] rate_ratio_q41;
    logic [63:0] upstream_tx_time_ns;
  } out_item_t;

endpackage

### hdl/ptp_sync_followup_receiver.sv
// ----------------------------------------------------------------------------
// ptp_sync_followup_receiver
// gPTP MD sync receive machine: latches Sync and Follow_Up, evaluates on ticks.
// ----------------------------------------------------------------------------
// Sync, Follow_Up, begin and non-emitting ticks only update registered state.
// A matching tick runs a bit-serial restoring divider for delay/ratio
// (P_DIV), a subtract step (P_SUB) and an output load step (P_OUT).
// Throughput: one item per cycle in P_IDLE; input is held off through P_DIV,
// P_SUB and P_OUT, longer if the previous result still waits in the output register.
// Reset: asynchronous, active low; machine in discard, ratio_q set to 31'h4000_0000, all other state cleared.
module ptp_sync_followup_receiver (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [319:0] s_axis_tdata,  // port_ready, time_ns, sequence_id, log_interval,
                                      // correction_scaled, origin_seconds,
                                      // origin_nanoseconds, rate_offset_scaled,
                                      // gm_base_indicator, gm_freq_change_scaled,
                                      // domain_number, 1 pad bit
  input  logic [1:0]   s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [311:0] m_axis_tdata,  // upstream_tx_time_ns, rate_ratio_q41,
                                      // correction_whole_ns, correction_frac,
                                      // sync_log_interval, origin_sec_out,
                                      // origin_ns_out, gm_base_out,
                                      // gm_freq_change_out, domain_out
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [1:0] {M_DISCARD, M_WAIT_SYNC, M_WAIT_FUP} mstate_e;
  typedef enum logic [1:0] {P_IDLE, P_DIV, P_SUB, P_OUT} pstate_e;

  ptpsfr_pkg::in_item_t in_item;
  assign in_item = ptpsfr_pkg::in_item_t'(s_axis_tdata);

  logic [31:0] delay_q;
  logic [30:0] ratio_q;
  mstate_e     mst_q;
  pstate_e     pst_q;
  logic        sync_pend_q, fup_pend_q;
  logic [63:0] deadline_q, ingress_q;
  logic [15:0] sync_seq_q, fup_seq_q;
  logic [7:0]  sync_int_q;
  logic [63:0] corr_q;
  logic [47:0] osec_q;
  logic [29:0] ons_q;
  logic [31:0] roff_q, gfreq_q;
  logic [15:0] gbase_q;
  logic [7:0]  dom_q;

  // divider
  logic [ptpsfr_pkg::DivW-1:0] dvd_q, quot_q;
  logic [ptpsfr_pkg::RatW-1:0] rem_q;
  logic [ptpsfr_pkg::CntW-1:0] cnt_q;
  logic [63:0]                 upstream_q;

  // output register
  ptpsfr_pkg::out_item_t out_q;
  logic                  out_valid_q;
  logic                  out_load;

  logic [30:0] divisor;
  logic [31:0] rem_sh, rem_sub;
  logic        rem_ge;
  logic        in_acc;
  logic [63:0] interval;
  logic signed [7:0] exp_c;

  assign s_axis_tready = (pst_q == P_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  // result moves to the output register once it is empty or being drained
  assign out_load      = (pst_q == P_OUT) && (!out_valid_q || m_axis_tready);

  assign divisor = (ratio_q == '0) ? 31'h4000_0000 : ratio_q;
  assign rem_sh  = {rem_q, dvd_q[ptpsfr_pkg::DivW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign rem_ge  = rem_sh >= {1'b0, divisor};

  // interval clamp to -31..31
  always_comb begin
    exp_c = $signed(sync_int_q);
    if (exp_c > 8'sd31) exp_c = 8'sd31;
    if (exp_c < -8'sd31) exp_c = -8'sd31;
    if (exp_c >= 0) interval = ptpsfr_pkg::NsInSec << exp_c[4:0];
    else            interval = ptpsfr_pkg::NsInSec >> (5'(-exp_c));
  end

  ptpsfr_pkg::out_item_t out_item;
  always_comb begin
    out_item.upstream_tx_time_ns = upstream_q;
    out_item.rate_ratio_q41      = 42'h200_0000_0000 + {{10{roff_q[31]}}, roff_q};
    out_item.correction_whole_ns = corr_q[63:16];
    out_item.correction_frac     = corr_q[15:0];
    out_item.sync_log_interval   = sync_int_q;
    out_item.origin_sec_out      = osec_q;
    out_item.origin_ns_out       = ons_q;
    out_item.gm_base_out         = gbase_q;
    out_item.gm_freq_change_out  = gfreq_q;
    out_item.domain_out          = dom_q;
  end
  assign m_axis_tdata = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= '0;
      ratio_q     <= 31'h4000_0000;
      mst_q       <= M_DISCARD;
      pst_q       <= P_IDLE;
      sync_pend_q <= 1'b0;
      fup_pend_q  <= 1'b0;
      deadline_q  <= '0;
      ingress_q   <= '0;
      sync_seq_q  <= '0;
      fup_seq_q   <= '0;
      sync_int_q  <= '0;
      corr_q      <= '0;
      osec_q      <= '0;
      ons_q       <= '0;
      roff_q      <= '0;
      gfreq_q     <= '0;
      gbase_q     <= '0;
      dom_q       <= '0;
      dvd_q       <= '0;
      quot_q      <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      upstream_q  <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_addr_i == 8'(ptpsfr_pkg::CFG_DELAY)) delay_q <= cfg_data_i;
        else if (cfg_addr_i == 8'(ptpsfr_pkg::CFG_RATIO)) ratio_q <= cfg_data_i[30:0];
      end
      if (out_load) begin
        out_q       <= out_item;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (pst_q)
        P_IDLE: begin
          if (in_acc) begin
            priority if (s_axis_tuser == ptpsfr_pkg::OP_SYNC) begin
              ingress_q   <= in_item.time_ns;
              sync_seq_q  <= in_item.sequence_id;
              sync_int_q  <= in_item.log_interval;
              sync_pend_q <= 1'b1;
            end else if (s_axis_tuser == ptpsfr_pkg::OP_FUP) begin
              corr_q     <= in_item.correction_scaled;
              osec_q     <= in_item.origin_seconds;
              ons_q      <= in_item.origin_nanoseconds;
              roff_q     <= in_item.rate_offset_scaled;
              gbase_q    <= in_item.gm_base_indicator;
              gfreq_q    <= in_item.gm_freq_change_scaled;
              dom_q      <= in_item.domain_number;
              fup_seq_q  <= in_item.sequence_id;
              fup_pend_q <= 1'b1;
            end else if (s_axis_tuser == ptpsfr_pkg::OP_BEGIN ||
                         (sync_pend_q && !in_item.port_ready)) begin
              mst_q       <= M_DISCARD;
              sync_pend_q <= 1'b0;
              fup_pend_q  <= 1'b0;
            end else if (mst_q == M_WAIT_FUP) begin
              if (fup_pend_q && fup_seq_q == sync_seq_q) begin
                fup_pend_q <= 1'b0;
                mst_q      <= M_WAIT_SYNC;
                dvd_q      <= {delay_q, 30'd0};
                rem_q      <= '0;
                quot_q     <= '0;
                cnt_q      <= ptpsfr_pkg::CntW'(ptpsfr_pkg::DivW - 1);
                pst_q      <= P_DIV;
              end else if (in_item.time_ns >= deadline_q) begin
                sync_pend_q <= 1'b0;
                fup_pend_q  <= 1'b0;
                mst_q       <= M_DISCARD;
              end
            end else if (sync_pend_q) begin
              sync_pend_q <= 1'b0;
              deadline_q  <= in_item.time_ns + interval;
              mst_q       <= M_WAIT_FUP;
            end
          end
        end
        P_DIV: begin
          // one quotient bit per cycle
          rem_q  <= rem_ge ? rem_sub[30:0] : rem_sh[30:0];
          quot_q <= {quot_q[ptpsfr_pkg::DivW-2:0], rem_ge};
          dvd_q  <= {dvd_q[ptpsfr_pkg::DivW-2:0], 1'b0};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) pst_q <= P_SUB;
        end
        P_SUB: begin
          upstream_q <= ingress_q - {2'b00, quot_q};
          pst_q      <= P_OUT;
        end
        P_OUT: begin
          if (out_load) pst_q <= P_IDLE;
        end
        default: pst_q <= P_IDLE;
      endcase
    end
  end

endmodule
